// ===== rtl/text_console_writer_assert.svh =====
// Assertion macros shared by the console writer modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    // Command codes of an input transaction.
    typedef enum logic [1:0] {
        CMD_PUT       = 2'd0,
        CMD_BACKSPACE = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    // Character codes and cell values.
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_BLANK  = 16'h0720;

    // Colour register reset values and register indexes.
    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;
    localparam logic       REG_FG   = 1'b0;
    localparam logic       REG_BG   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic read_cap;
        logic copy_step;
        logic fill_step;
        logic fill_init;
    } tcw_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t op_cmd;
        logic scroll_req;
        logic fill_last;
        logic copy_last;
    } tcw_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire tcw_stat_t stat,
    output tcw_ctrl_t      ctrl,
    output logic           busy,
    output logic           done
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b000_0001,
        ST_IDLE  = 7'b000_0010,
        ST_EXEC  = 7'b000_0100,
        ST_READ  = 7'b000_1000,
        ST_COPY  = 7'b001_0000,
        ST_CLEAR = 7'b010_0000,
        ST_DONE  = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctrl.fill_step = 1'b1;
                ctrl.fill_init = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                case (stat.op_cmd)
                    CMD_READ:  state_next = ST_READ;
                    CMD_CLEAR: state_next = ST_CLEAR;
                    CMD_PUT:   state_next = stat.scroll_req ? ST_COPY : ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                ctrl.read_cap = 1'b1;
                state_next    = ST_DONE;
            end
            ST_COPY:
            begin
                ctrl.copy_step = 1'b1;
                if (stat.copy_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                ctrl.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    // A result strobe lasts one cycle and the block is free right after it.
    `TCW_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
    // An accepted transaction always starts execution in the next cycle.
    `TCW_ASSERT_NEXT(a_start_exec, start && !busy, state_reg == ST_EXEC, "accepted transaction not executed")
    // A scroll copy only ends on the final store entry.
    `TCW_ASSERT_NEXT(a_copy_hold, (state_reg == ST_COPY) && !stat.copy_last, state_reg == ST_COPY, "scroll copy ended early")

endmodule

`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tcw_ctrl_t   ctrl,
    output tcw_stat_t        stat,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [10:0] cell_index,
    input  wire logic [3:0]  fg_colour,
    input  wire logic [3:0]  bg_colour,
    output logic [15:0]      cell_word,
    output logic [10:0]      cursor_pos,
    output logic             scrolled
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int COL_W      = $clog2(COLUMNS);

    // Screen store, one port written and one read per cycle.
    logic [15:0] screen_mem [CELL_COUNT];
    logic [15:0] rdata_reg;

    // Latched transaction.
    cmd_t        op_cmd_reg;
    logic [7:0]  op_char_reg;
    logic [10:0] op_idx_reg;

    // Cursor as linear address plus column.
    logic [ADDR_W-1:0] cursor_addr_reg;
    logic [ADDR_W-1:0] cursor_addr_next;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [COL_W-1:0]  cursor_col_next;

    // Sweep pointer for fill and scroll copy.
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;

    // Result registers.
    logic [15:0] word_reg;
    logic        scrolled_reg;

    logic [15:0]       blank;
    logic              is_nl;
    logic [PTR_W-1:0]  step_inc;
    logic [PTR_W-1:0]  adv_addr;
    logic              overflow;
    logic              col_wrap;
    logic              in_range;
    logic [ADDR_W+10:0] idx_wide;
    logic [PTR_W-1:0]  copy_src;
    logic [PTR_W-1:0]  copy_dst;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W+10:0] pos_wide;

    assign blank = {bg_colour, fg_colour, SPACE_CODE};

    // Cursor advance for a put: one cell, or to the start of the next row on newline.
    assign is_nl    = (op_char_reg == NEWLINE_CODE);
    assign step_inc = is_nl ? (PTR_W'(COLUMNS) - PTR_W'(cursor_col_reg)) : PTR_W'(1);
    assign adv_addr = {1'b0, cursor_addr_reg} + step_inc;
    assign overflow = (adv_addr >= PTR_W'(CELL_COUNT));
    assign col_wrap = is_nl || (cursor_col_reg == COL_W'(COLUMNS - 1));

    // Read index check and store address.
    assign in_range = (32'(op_idx_reg) < 32'(CELL_COUNT));
    assign idx_wide = {{ADDR_W{1'b0}}, op_idx_reg};

    // Scroll copy: entry ptr-1 takes the entry one row below, or a blank on the last row.
    assign copy_src = ptr_reg + PTR_W'(COLUMNS);
    assign copy_dst = ptr_reg - PTR_W'(1);

    // Store write and read port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cursor_addr_reg;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = idx_wide[ADDR_W-1:0];
        if (ctrl.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg[ADDR_W-1:0];
            mem_wdata = ctrl.fill_init ? RESET_BLANK : blank;
        end
        else if (ctrl.copy_step)
        begin
            mem_we    = (ptr_reg != '0);
            mem_waddr = copy_dst[ADDR_W-1:0];
            mem_wdata = (copy_dst < PTR_W'(LAST_BASE)) ? rdata_reg : blank;
            mem_re    = (copy_src < PTR_W'(CELL_COUNT));
            mem_raddr = copy_src[ADDR_W-1:0];
        end
        else if (ctrl.exec)
        begin
            case (op_cmd_reg)
                CMD_PUT:
                begin
                    mem_we    = !is_nl;
                    mem_wdata = {bg_colour, fg_colour, op_char_reg};
                end
                CMD_BACKSPACE:
                begin
                    mem_we    = (cursor_col_reg != '0);
                    mem_waddr = cursor_addr_reg - ADDR_W'(1);
                end
                CMD_READ:
                begin
                    mem_re = in_range;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Screen store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // Cursor and sweep pointer next values.
    always_comb
    begin
        cursor_addr_next = cursor_addr_reg;
        cursor_col_next  = cursor_col_reg;
        ptr_next         = ptr_reg;
        if (ctrl.fill_step || ctrl.copy_step)
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
        else if (ctrl.exec)
        begin
            ptr_next = '0;
            case (op_cmd_reg)
                CMD_PUT:
                begin
                    cursor_addr_next = overflow ? ADDR_W'(LAST_BASE) : adv_addr[ADDR_W-1:0];
                    cursor_col_next  = col_wrap ? '0 : cursor_col_reg + COL_W'(1);
                end
                CMD_BACKSPACE:
                begin
                    if (cursor_col_reg != '0)
                    begin
                        cursor_addr_next = cursor_addr_reg - ADDR_W'(1);
                        cursor_col_next  = cursor_col_reg - COL_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    cursor_addr_next = '0;
                    cursor_col_next  = '0;
                end
                default:
                begin
                    cursor_addr_next = cursor_addr_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_addr_reg <= '0;
            cursor_col_reg  <= '0;
            ptr_reg         <= '0;
        end
        else
        begin
            cursor_addr_reg <= cursor_addr_next;
            cursor_col_reg  <= cursor_col_next;
            ptr_reg         <= ptr_next;
        end
    end

    // Transaction latch and result registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_cmd_reg  <= cmd_t'(cmd);
            op_char_reg <= char_code;
            op_idx_reg  <= cell_index;
        end
        if (ctrl.exec)
        begin
            word_reg     <= '0;
            scrolled_reg <= (op_cmd_reg == CMD_PUT) && overflow;
        end
        if (ctrl.read_cap)
        begin
            word_reg <= in_range ? rdata_reg : '0;
        end
    end

    // Status to the controller.
    assign stat.op_cmd     = op_cmd_reg;
    assign stat.scroll_req = overflow;
    assign stat.fill_last  = (ptr_reg == PTR_W'(CELL_COUNT - 1));
    assign stat.copy_last  = (ptr_reg == PTR_W'(CELL_COUNT));

    // Result fields.
    assign pos_wide   = {11'b0, cursor_addr_reg};
    assign cursor_pos = pos_wide[10:0];
    assign cell_word  = word_reg;
    assign scrolled   = scrolled_reg;

    // Only one datapath command is active in any cycle.
    `TCW_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({ctrl.load, ctrl.exec, ctrl.read_cap, ctrl.copy_step, ctrl.fill_step}), "conflicting datapath commands")
    // The cursor never leaves the screen.
    `TCW_ASSERT_NOW(a_cursor_range, 1'b1, 32'(cursor_addr_reg) < 32'(CELL_COUNT), "cursor outside the screen")

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------
// command   | start, busy        | cmd, char_code, cell_index
// result    | done (strobe)      | cell_word, cursor_pos, scrolled
// config    | psel, penable, ... | paddr, pwdata, prdata
//
// A transaction is taken when start is high and busy is low; its result
// strobe follows the execute state for put and backspace, and the execute
// and read-capture states for read. Clear adds a fill sweep and a scrolling
// put a copy sweep, one store entry per cycle through the single write port
// of the store. After reset a clearing pass holds busy high.
// The receiver cannot stall: each result is valid for the strobe cycle only.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [10:0] cell_index,
    output logic             done,
    output logic [15:0]      cell_word,
    output logic [10:0]      cursor_pos,
    output logic             scrolled,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0] fg_reg;
    logic [3:0] bg_reg;
    logic       reg_sel;
    logic       wr_en;
    tcw_ctrl_t  ctrl;
    tcw_stat_t  stat;

    // Colour registers on the configuration port.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_FG)
            begin
                fg_reg <= pwdata[3:0];
            end
            else
            begin
                bg_reg <= pwdata[3:0];
            end
        end
    end

    // Register read back.
    assign prdata = (reg_sel == REG_BG) ? {28'b0, bg_reg} : {28'b0, fg_reg};

    // Controller.
    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // Screen store, cursor and sweep datapath.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .fg_colour  (fg_reg),
        .bg_colour  (bg_reg),
        .cell_word  (cell_word),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    import tcw_pkg::*;

    localparam int COLS        = 80;
    localparam int ROW_COUNT   = 25;
    localparam int CELLS       = COLS * ROW_COUNT;
    localparam int STALL_LIMIT = 20000;

    // Result of one transaction as the console should report it.
    typedef struct packed {
        logic [15:0] cell_word;
        logic [10:0] cursor_pos;
        logic        scrolled;
    } console_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    cmd_t        cmd = CMD_PUT;
    logic [7:0]  char_code = 8'h00;
    logic [10:0] cell_index = 11'd0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic        busy;
    logic        done;
    logic [15:0] cell_word;
    logic [10:0] cursor_pos;
    logic        scrolled;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the screen, cursor and colour registers.
    logic [15:0]    screen_shadow [0:CELLS-1];
    int unsigned    shadow_row;
    int unsigned    shadow_col;
    logic [3:0]     shadow_fg;
    logic [3:0]     shadow_bg;
    console_reply_t expected_replies [$];

    int error_count = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;

    text_console_writer #(
        .COLUMNS (COLS),
        .ROWS    (ROW_COUNT)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .done       (done),
        .cell_word  (cell_word),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A blank or written cell carries the current colours in its high byte.
    function automatic logic [15:0] colour_cell(logic [7:0] ch);
        return {shadow_bg, shadow_fg, ch};
    endfunction

    // Applies one accepted transaction to the shadow screen and queues its reply.
    task automatic predict_console_step(cmd_t op, logic [7:0] ch, logic [10:0] idx);
        console_reply_t reply;
        reply = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch != NEWLINE_CODE)
                    screen_shadow[shadow_row * COLS + shadow_col] = colour_cell(ch);
                shadow_col++;
                if (shadow_col >= COLS || ch == NEWLINE_CODE)
                begin
                    shadow_col = 0;
                    shadow_row++;
                    // Past the last row the screen moves up and the bottom row is blanked.
                    if (shadow_row >= ROW_COUNT)
                    begin
                        for (int i = 0; i < CELLS - COLS; i++)
                            screen_shadow[i] = screen_shadow[i + COLS];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            screen_shadow[i] = colour_cell(SPACE_CODE);
                        shadow_row = ROW_COUNT - 1;
                        reply.scrolled = 1'b1;
                    end
                end
            end
            CMD_BACKSPACE:
            begin
                // At column zero a backspace leaves everything as it is.
                if (shadow_col > 0)
                begin
                    shadow_col--;
                    screen_shadow[shadow_row * COLS + shadow_col] = colour_cell(SPACE_CODE);
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = colour_cell(SPACE_CODE);
                shadow_row = 0;
                shadow_col = 0;
            end
            default:
            begin
                if (idx < CELLS)
                    reply.cell_word = screen_shadow[idx];
            end
        endcase
        reply.cursor_pos = 11'(shadow_row * COLS + shadow_col);
        expected_replies.push_back(reply);
    endtask

    // Presents one transaction, waits until it is taken, then maybe idles the sender.
    task automatic issue_command(cmd_t op, logic [7:0] ch, logic [10:0] idx);
        int gap;
        start <= 1'b1;
        cmd <= op;
        char_code <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_console_step(op, ch, idx);
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every queued reply has come and the block is idle.
    task automatic wait_console_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Setup and access phase of one register write; psel is left high.
    task automatic apb_write(logic reg_index, logic [3:0] value);
        logic [31:0] noise;
        noise = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= {noise[31:4], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_index == REG_FG)
            shadow_fg = value;
        else
            shadow_bg = value;
    endtask

    task automatic program_colours(logic [3:0] fg, logic [3:0] bg);
        apb_write(REG_FG, fg);
        apb_write(REG_BG, bg);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Extreme character codes with reset colours, and reads at the ends of the index range.
    task automatic test_put_extremes();
        issue_command(CMD_PUT, 8'h00, 11'h7FF);
        issue_command(CMD_PUT, 8'hFF, 11'd0);
        issue_command(CMD_READ, 8'hFF, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd1);
        issue_command(CMD_READ, 8'h00, 11'd1999);
        issue_command(CMD_READ, 8'h00, 11'd2000);
        issue_command(CMD_READ, 8'h00, 11'h7FF);
    endtask

    // Backspace in the middle of a row and at column zero, and newline.
    task automatic test_line_edit();
        issue_command(CMD_BACKSPACE, 8'h00, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd1);
        issue_command(CMD_PUT, NEWLINE_CODE, 11'd0);
        issue_command(CMD_BACKSPACE, 8'hFF, 11'h7FF);
        issue_command(CMD_PUT, 8'h41, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd80);
    endtask

    // Clear with all colour bits set, then a write on the fresh screen.
    task automatic test_clear();
        wait_console_idle();
        program_colours(4'hF, 4'hF);
        issue_command(CMD_CLEAR, 8'hFF, 11'h7FF);
        issue_command(CMD_READ, 8'h00, 11'd80);
        issue_command(CMD_PUT, 8'h5A, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd0);
    endtask

    // Newlines down to the bottom row and one more to scroll the screen up.
    task automatic test_scroll();
        wait_console_idle();
        program_colours(4'h0, 4'h0);
        issue_command(CMD_CLEAR, 8'h00, 11'd0);
        issue_command(CMD_PUT, 8'h54, 11'd0);
        for (int r = 0; r < ROW_COUNT - 1; r++)
            issue_command(CMD_PUT, NEWLINE_CODE, 11'd0);
        issue_command(CMD_PUT, 8'h42, 11'd0);
        issue_command(CMD_PUT, NEWLINE_CODE, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'((ROW_COUNT - 2) * COLS));
        issue_command(CMD_READ, 8'h00, 11'((ROW_COUNT - 1) * COLS));
    endtask

    // Mostly text with random content; newline density changes from stretch to stretch.
    task automatic run_random_phase(int count);
        int newline_pct;
        int pick;
        int base;
        logic [7:0] ch;
        logic [10:0] idx;
        newline_pct = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                pick = $urandom_range(2);
                newline_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 25;
            end
            ch = $urandom_range(255);
            idx = $urandom_range(2047);
            pick = $urandom_range(99);
            if (pick < 2)
                issue_command(CMD_CLEAR, ch, idx);
            else if (pick < 12)
                issue_command(CMD_BACKSPACE, ch, idx);
            else if (pick < 32)
            begin
                // Most reads land on or just above the cursor row.
                if ($urandom_range(2) != 0)
                begin
                    base = int'(shadow_row) * COLS - int'($urandom_range(1)) * COLS;
                    if (base < 0)
                        base = 0;
                    idx = 11'(base + $urandom_range(COLS - 1));
                end
                issue_command(CMD_READ, ch, idx);
            end
            else
            begin
                if ($urandom_range(99) < newline_pct)
                    ch = NEWLINE_CODE;
                issue_command(CMD_PUT, ch, idx);
            end
        end
    endtask

    // Phases differ in sender idling and in colours; each starts from an idle block.
    task automatic test_random_traffic();
        logic [3:0] fg_set [0:3];
        logic [3:0] bg_set [0:3];
        fg_set = '{4'h0, 4'hF, 4'h0, 4'hF};
        bg_set = '{4'h0, 4'hF, 4'hF, 4'h0};
        for (int p = 0; p < 6; p++)
        begin
            wait_console_idle();
            if (p < 4)
                program_colours(fg_set[p], bg_set[p]);
            else
                program_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
            sender_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 71 : 27;
            run_random_phase(205);
        end
    endtask

    // Compares one field of a reply and reports a mismatch.
    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Each result strobe is matched against the oldest reply still expected.
    always @(posedge clk)
    begin
        console_reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: result with no transaction pending: expected none, actual %h %0d %b",
                         $time, cell_word, cursor_pos, scrolled);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                compare_field("cell_word", want.cell_word, cell_word);
                compare_field("cursor_pos", want.cursor_pos, cursor_pos);
                compare_field("scrolled", want.scrolled, scrolled);
            end
        end
    end

    // Counts cycles in which neither a command nor a result is taken.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = RESET_BLANK;
        shadow_row = 0;
        shadow_col = 0;
        shadow_fg = FG_RESET;
        shadow_bg = BG_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_put_extremes();
        test_line_edit();
        test_clear();
        test_scroll();
        test_random_traffic();

        // Let any stray result show up before the verdict.
        wait_console_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
